// ===== src/bms_info_frame_parser_unit_defines.svh =====
// Assertion macros shared by the frame parser modules.
// Depends on nothing; expects clk and rst_n in the scope of each use.
`ifndef BMS_INFO_FRAME_PARSER_UNIT_DEFINES_SVH
`define BMS_INFO_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define BMSIFP_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("bmsifp: same-cycle check failed");

// next-cycle implication
`define BMSIFP_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("bmsifp: next-cycle check failed");

`endif

// ===== src/bmsifp_pkg.sv =====
// Types, constants and decode functions of the info frame parser.
// Used by bmsifp_ctrl, bmsifp_dp and the top level; depends on nothing.
package bmsifp_pkg;

  localparam int STORE_BYTES_DEF = 64;
  localparam int MAX_SENSORS_DEF = 8;

  localparam int HELD_W = 17;

  localparam logic [7:0]        HDR_START   = 8'hDD;
  localparam logic [7:0]        HDR_CMD     = 8'h03;
  localparam logic [HELD_W-1:0] FRAME_OVHD  = 17'd7;
  localparam logic [HELD_W-1:0] MIN_FRAME   = 17'd40;
  localparam logic [HELD_W-1:0] HDR_BYTES   = 17'd4;
  localparam logic [16:0]       YEAR_BASE   = 17'd2000;
  localparam logic [16:0]       TEMP_OFFSET = 17'd2731;
  localparam logic [6:0]        TEMP_BASE   = 7'd27;

  typedef enum logic [3:0] {
    KIND_VOLT     = 4'd0,
    KIND_CURRENT  = 4'd1,
    KIND_REMAIN   = 4'd2,
    KIND_FULL     = 4'd3,
    KIND_CYCLES   = 4'd4,
    KIND_YEAR     = 4'd5,
    KIND_MONTH    = 4'd6,
    KIND_DAY      = 4'd7,
    KIND_BALANCE  = 4'd8,
    KIND_PROTECT  = 4'd9,
    KIND_SOC      = 4'd10,
    KIND_CELLS    = 4'd11,
    KIND_SENSORS  = 4'd12,
    KIND_TEMP     = 4'd13
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_BUILD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic store;   // write the accepted word, bump the count
    logic clear;   // empty the frame
    logic start;   // rewind field sequencer
    logic rd_hi;   // read high byte of the current field
    logic rd_lo;   // read low byte of the current field
    logic build;   // load the result register
    logic next;    // step to the next field
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ge4;
    logic hdr_ok;
    logic complete;
    logic big;
    logic last;
    logic out_free;
  } sts_t;

  // Word address of each fixed field; single-byte fields fetch the word
  // ending at that byte and use its low half.
  function automatic logic [6:0] fetch_base(kind_t kind);
    logic [6:0] a;
    unique case (kind)
      KIND_VOLT:    a = 7'd4;
      KIND_CURRENT: a = 7'd6;
      KIND_REMAIN:  a = 7'd8;
      KIND_FULL:    a = 7'd10;
      KIND_CYCLES:  a = 7'd12;
      KIND_YEAR,
      KIND_MONTH,
      KIND_DAY:     a = 7'd14;
      KIND_BALANCE: a = 7'd16;
      KIND_PROTECT: a = 7'd18;
      KIND_SOC:     a = 7'd21;
      KIND_CELLS:   a = 7'd24;
      KIND_SENSORS: a = 7'd25;
      default:      a = TEMP_BASE;
    endcase
    return a;
  endfunction

endpackage

// ===== src/bmsifp_ctrl.sv =====
// Controller of the info frame parser: sequences store, check and field fetch.
// Depends on bmsifp_pkg and bms_info_frame_parser_unit_defines.svh.
`include "bms_info_frame_parser_unit_defines.svh"

module bmsifp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_chunk_end,
  output logic               in_ready,
  input  bmsifp_pkg::sts_t   sts,
  output bmsifp_pkg::cmd_t   cmd
);

  bmsifp_pkg::state_t state_r, state_nxt;

  logic parse_ok;
  assign parse_ok = sts.ge4 && sts.hdr_ok && sts.complete && sts.big;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmsifp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bmsifp_pkg::ST_IDLE: begin
        if (in_valid && in_chunk_end) state_nxt = bmsifp_pkg::ST_CHECK;
      end
      bmsifp_pkg::ST_CHECK: begin
        state_nxt = parse_ok ? bmsifp_pkg::ST_FETCH_HI : bmsifp_pkg::ST_IDLE;
      end
      bmsifp_pkg::ST_FETCH_HI: state_nxt = bmsifp_pkg::ST_FETCH_LO;
      bmsifp_pkg::ST_FETCH_LO: state_nxt = bmsifp_pkg::ST_BUILD;
      bmsifp_pkg::ST_BUILD: begin
        if (sts.out_free) begin
          state_nxt = sts.last ? bmsifp_pkg::ST_IDLE : bmsifp_pkg::ST_FETCH_HI;
        end
      end
      default: state_nxt = bmsifp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      bmsifp_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
      end
      bmsifp_pkg::ST_CHECK: begin
        // bad header, or a complete frame too short to parse: drop it
        cmd.clear = sts.ge4 && (!sts.hdr_ok || (sts.complete && !sts.big));
        cmd.start = parse_ok;
      end
      bmsifp_pkg::ST_FETCH_HI: cmd.rd_hi = 1'b1;
      bmsifp_pkg::ST_FETCH_LO: cmd.rd_lo = 1'b1;
      bmsifp_pkg::ST_BUILD: begin
        cmd.build = sts.out_free;
        cmd.clear = sts.out_free && sts.last;
        cmd.next  = sts.out_free && !sts.last;
      end
      default: ;
    endcase
  end

  `BMSIFP_ASSERT_IMP(a_check_after_idle, state_r == bmsifp_pkg::ST_CHECK, $past(state_r) == bmsifp_pkg::ST_IDLE)
  `BMSIFP_ASSERT_IMP(a_lo_after_hi, state_r == bmsifp_pkg::ST_FETCH_LO, $past(state_r) == bmsifp_pkg::ST_FETCH_HI)
  `BMSIFP_ASSERT_NXT(a_build_waits, (state_r == bmsifp_pkg::ST_BUILD) && !sts.out_free, state_r == bmsifp_pkg::ST_BUILD)

endmodule

// ===== src/bmsifp_dp.sv =====
// Datapath of the info frame parser: frame store, count, header, field decode.
// Depends on bmsifp_pkg and bms_info_frame_parser_unit_defines.svh.
`include "bms_info_frame_parser_unit_defines.svh"

module bmsifp_dp #(
  parameter int STORE_BYTES = bmsifp_pkg::STORE_BYTES_DEF,
  parameter int MAX_SENSORS = bmsifp_pkg::MAX_SENSORS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_data_byte,
  input  bmsifp_pkg::cmd_t    cmd,
  output bmsifp_pkg::sts_t    sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_item_kind,
  output logic signed [16:0]  out_value,
  output logic [4:0]          out_sensor_index,
  output logic                out_last
);

  localparam int                                IDX_W     = $clog2(STORE_BYTES);
  localparam logic [8:0]                        STORE_LIM = 9'(STORE_BYTES);
  localparam logic [bmsifp_pkg::HELD_W-1:0]     STORE_CNT = bmsifp_pkg::HELD_W'(STORE_BYTES);
  localparam logic [7:0]                        MAX_B     = 8'(MAX_SENSORS);
  localparam logic [5:0]                        MAX_6     = 6'(MAX_SENSORS);

  logic [7:0] mem [STORE_BYTES];

  logic [bmsifp_pkg::HELD_W-1:0] held_r;
  logic [7:0]                    hdr_r [4];
  bmsifp_pkg::kind_t             kind_r;
  logic [4:0]                    sens_r;
  logic [5:0]                    lim_r;
  logic [7:0]                    rd_data_r;
  logic [7:0]                    hi_r;

  logic                          out_valid_r;
  bmsifp_pkg::kind_t             out_kind_r;
  logic signed [16:0]            out_value_r;
  logic [4:0]                    out_index_r;
  logic                          out_last_r;

  logic [6:0]  word_addr;
  logic [6:0]  rd_addr;
  logic [8:0]  rd_addr_x;
  logic [15:0] word;
  logic [16:0] value_now;
  logic [5:0]  lim_now;
  logic        more_temps;
  logic        last_now;

  // ---- store and count ----
  always_ff @(posedge clk) begin
    if (cmd.store && (held_r < STORE_CNT)) begin
      mem[held_r[IDX_W-1:0]] <= in_data_byte;
    end
    if (cmd.rd_hi || cmd.rd_lo) begin
      rd_data_r <= (rd_addr_x < STORE_LIM) ? mem[rd_addr_x[IDX_W-1:0]] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && (held_r < bmsifp_pkg::HDR_BYTES)) begin
      hdr_r[held_r[1:0]] <= in_data_byte;
    end
    if (cmd.rd_lo) hi_r <= rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.clear) begin
      held_r <= '0;
    end else if (cmd.store && (held_r != '1)) begin
      held_r <= held_r + 1'b1;
    end
  end

  assign sts.ge4      = held_r >= bmsifp_pkg::HDR_BYTES;
  assign sts.hdr_ok   = (hdr_r[0] == bmsifp_pkg::HDR_START) && (hdr_r[1] == bmsifp_pkg::HDR_CMD);
  assign sts.complete = held_r >= (bmsifp_pkg::FRAME_OVHD +
                                   bmsifp_pkg::HELD_W'({hdr_r[2], hdr_r[3]}));
  assign sts.big      = held_r >= bmsifp_pkg::MIN_FRAME;

  // ---- field sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= bmsifp_pkg::KIND_VOLT;
      sens_r <= '0;
    end else if (cmd.start) begin
      kind_r <= bmsifp_pkg::KIND_VOLT;
      sens_r <= '0;
    end else if (cmd.next) begin
      if (kind_r == bmsifp_pkg::KIND_TEMP) sens_r <= sens_r + 1'b1;
      else kind_r <= bmsifp_pkg::kind_t'(kind_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build && (kind_r == bmsifp_pkg::KIND_SENSORS)) lim_r <= lim_now;
  end

  assign word_addr = (kind_r == bmsifp_pkg::KIND_TEMP)
                   ? bmsifp_pkg::TEMP_BASE + 7'({sens_r, 1'b0})
                   : bmsifp_pkg::fetch_base(kind_r);
  assign rd_addr   = cmd.rd_lo ? word_addr + 7'd1 : word_addr;
  assign rd_addr_x = 9'(rd_addr);

  // ---- field decode ----
  assign word    = {hi_r, rd_data_r};
  assign lim_now = (rd_data_r < MAX_B) ? rd_data_r[5:0] : MAX_B[5:0];

  always_comb begin
    case (kind_r)
      bmsifp_pkg::KIND_CURRENT: value_now = {word[15], word};
      bmsifp_pkg::KIND_YEAR:    value_now = 17'(word[15:9]) + bmsifp_pkg::YEAR_BASE;
      bmsifp_pkg::KIND_MONTH:   value_now = 17'(word[8:5]);
      bmsifp_pkg::KIND_DAY:     value_now = 17'(word[4:0]);
      bmsifp_pkg::KIND_SOC,
      bmsifp_pkg::KIND_CELLS,
      bmsifp_pkg::KIND_SENSORS: value_now = 17'(rd_data_r);
      bmsifp_pkg::KIND_TEMP:    value_now = {1'b0, word} - bmsifp_pkg::TEMP_OFFSET;
      default:                  value_now = {1'b0, word};
    endcase
  end

  // another sensor follows if within the limit and its word is fully held
  always_comb begin
    case (kind_r)
      bmsifp_pkg::KIND_SENSORS:
        more_temps = (lim_now != 6'd0) &&
                     (bmsifp_pkg::HELD_W'(bmsifp_pkg::TEMP_BASE) + 17'd1 < held_r);
      bmsifp_pkg::KIND_TEMP:
        more_temps = (({1'b0, sens_r} + 6'd1) < lim_r) &&
                     (bmsifp_pkg::HELD_W'(bmsifp_pkg::TEMP_BASE) +
                      bmsifp_pkg::HELD_W'({sens_r, 1'b0}) + 17'd3 < held_r);
      default:
        more_temps = 1'b1;
    endcase
  end

  assign last_now = !more_temps;
  assign sts.last = last_now;

  // ---- result register ----
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.build) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build) begin
      out_kind_r  <= kind_r;
      out_value_r <= value_now;
      out_index_r <= (kind_r == bmsifp_pkg::KIND_TEMP) ? sens_r : 5'd0;
      out_last_r  <= last_now;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_item_kind    = out_kind_r;
  assign out_value        = out_value_r;
  assign out_sensor_index = out_index_r;
  assign out_last         = out_last_r;

  `BMSIFP_ASSERT_NXT(a_held_grows, !cmd.clear, held_r >= $past(held_r))
  `BMSIFP_ASSERT_IMP(a_last_kind, out_valid_r && out_last_r, (out_kind_r == bmsifp_pkg::KIND_SENSORS) || (out_kind_r == bmsifp_pkg::KIND_TEMP))
  `BMSIFP_ASSERT_IMP(a_temp_index, out_valid_r && (out_kind_r == bmsifp_pkg::KIND_TEMP), {1'b0, out_index_r} < MAX_6)

endmodule

// ===== src/bms_info_frame_parser_unit.sv =====
// Input: a word without chunk end is stored as it is taken; a chunk-end word is
// stored, then the header/length check against the held count follows.
// After the check, a parsed frame gives 13 + up to MAX_SENSORS results, each read
// through the single read port of the frame store (high byte, low byte, build);
// build waits on a full result register; no word is taken until the last is built.
// Reset: synchronous, clears byte count, sequencer and output valid; no clearing pass.
//
// Top level of the battery-monitor basic-info reply parser.
// Depends on bmsifp_pkg, bmsifp_ctrl and bmsifp_dp.
module bms_info_frame_parser_unit #(
  parameter int STORE_BYTES = bmsifp_pkg::STORE_BYTES_DEF,
  parameter int MAX_SENSORS = bmsifp_pkg::MAX_SENSORS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,

  // reply words in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_chunk_end,

  // decoded fields out
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_item_kind,
  output logic signed [16:0]  out_value,
  output logic [4:0]          out_sensor_index,
  output logic                out_last
);

  // Controller owns the handshake on the input side and walks the fields;
  // datapath holds the store, the count, the header bytes and the result
  // register, which lets a new frame start while the last result waits.
  bmsifp_pkg::cmd_t cmd;
  bmsifp_pkg::sts_t sts;

  bmsifp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_chunk_end (in_chunk_end),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  bmsifp_dp #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_SENSORS (MAX_SENSORS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_data_byte     (in_data_byte),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item_kind    (out_item_kind),
    .out_value        (out_value),
    .out_sensor_index (out_sensor_index),
    .out_last         (out_last)
  );

endmodule
